// File: rtl/rpi_pkg.sv
// Shared types, register codes and constants for the ray/plane intersection core.
package rpi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int MAG_W         = 64;
	localparam int SUM_W         = 66;
	localparam int QLOW_W        = 62;
	localparam int Q_W           = 63;
	localparam int SAT_BIT       = 62;
	localparam int REG_IDX_W     = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_NORMAL_X     = 2'd0,
		REG_NORMAL_Y     = 2'd1,
		REG_NORMAL_Z     = 2'd2,
		REG_PLANE_OFFSET = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] start_x;
		logic signed [DATA_W-1:0] start_y;
		logic signed [DATA_W-1:0] start_z;
		logic signed [DATA_W-1:0] dir_x;
		logic signed [DATA_W-1:0] dir_y;
		logic signed [DATA_W-1:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] point_x;
		logic signed [DATA_W-1:0] point_y;
		logic signed [DATA_W-1:0] point_z;
	} result_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] normal_x;
		logic signed [DATA_W-1:0] normal_y;
		logic signed [DATA_W-1:0] normal_z;
		logic signed [DATA_W-1:0] plane_offset;
	} plane_t;

	// classified ray handed from the front end to the divider
	typedef struct packed {
		ray_t             ray;
		logic [MAG_W-1:0] nm;
		logic [MAG_W-1:0] zm;
		logic             sneg;
		logic             nok;
	} mid_t;

	// epsilon in LSBs: round(0.0001 * 2^f)
	function automatic logic [MAG_W-1:0] eps_lsb(input int f);
		eps_lsb = ((64'd1 << f) + 64'd5000) / 64'd10000;
	endfunction

endpackage

// File: rtl/rpi_fifo.sv
// Small register queue used between the pipeline parts and at the result side.
module rpi_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// store entry
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/rpi_front.sv
// Front end: takes rays, forms both dot products and classifies the denominator.
module rpi_front #(
	parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  rpi_pkg::ray_t   ray,
	input  rpi_pkg::plane_t plane,
	output logic            mid_wr,
	output rpi_pkg::mid_t   mid_item,
	input  logic            mid_full
);
	import rpi_pkg::*;

	localparam logic [MAG_W-1:0] N_EPS = eps_lsb(FRAC_BITS) << FRAC_BITS;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        adv;
	ray_t        ray_s1, ray_s2, ray_s3, ray_s4;
	logic signed [MAG_W-1:0] pn_s2 [3];
	logic signed [MAG_W-1:0] pz_s2 [3];
	logic signed [SUM_W-1:0] doff_s2;
	logic signed [SUM_W-1:0] n_s3, z_s3;
	logic [MAG_W-1:0]        nm_s4, zm_s4;
	logic                    sneg_s4, nok_s4;
	logic                    nneg, zneg;
	logic signed [SUM_W-1:0] nabs, zabs;

	assign adv  = !v_s4 || !mid_full;
	assign full = !adv;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// magnitude and sign of both sums
	always_comb begin
		nneg = n_s3[SUM_W-1];
		zneg = z_s3[SUM_W-1];
		nabs = nneg ? -n_s3 : n_s3;
		zabs = zneg ? -z_s3 : z_s3;
	end

	// products, sums, classification
	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1 <= ray;
			ray_s2 <= ray_s1;
			pn_s2[0] <= MAG_W'(ray_s1.dir_x) * MAG_W'(plane.normal_x);
			pn_s2[1] <= MAG_W'(ray_s1.dir_y) * MAG_W'(plane.normal_y);
			pn_s2[2] <= MAG_W'(ray_s1.dir_z) * MAG_W'(plane.normal_z);
			pz_s2[0] <= MAG_W'(ray_s1.start_x) * MAG_W'(plane.normal_x);
			pz_s2[1] <= MAG_W'(ray_s1.start_y) * MAG_W'(plane.normal_y);
			pz_s2[2] <= MAG_W'(ray_s1.start_z) * MAG_W'(plane.normal_z);
			doff_s2  <= SUM_W'(plane.plane_offset) <<< FRAC_BITS;
			ray_s3 <= ray_s2;
			n_s3 <= SUM_W'(pn_s2[0]) + SUM_W'(pn_s2[1]) + SUM_W'(pn_s2[2]);
			z_s3 <= SUM_W'(pz_s2[0]) + SUM_W'(pz_s2[1]) + SUM_W'(pz_s2[2]) + doff_s2;
			ray_s4  <= ray_s3;
			nm_s4   <= nabs[MAG_W-1:0];
			zm_s4   <= zabs[MAG_W-1:0];
			sneg_s4 <= (zneg == nneg);
			nok_s4  <= (nabs[MAG_W-1:0] > N_EPS);
		end
	end

	assign mid_wr        = v_s4 && adv;
	assign mid_item.ray  = ray_s4;
	assign mid_item.nm   = nm_s4;
	assign mid_item.zm   = zm_s4;
	assign mid_item.sneg = sneg_s4;
	assign mid_item.nok  = nok_s4;

endmodule

// File: rtl/rpi_back.sv
// Back end: pipelined restoring divider for the ray parameter and the point update.
module rpi_back #(
	parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_empty,
	input  rpi_pkg::mid_t     mid_item,
	output logic              mid_rd,
	output logic              res_wr,
	output rpi_pkg::result_t  res_item,
	input  logic              res_full
);
	import rpi_pkg::*;

	localparam int               DW    = MAG_W + FRAC_BITS;
	localparam logic [Q_W-1:0]   S_EPS = Q_W'(eps_lsb(FRAC_BITS));
	localparam logic [33:0]      M_BIG = 34'h2_0000_0000;

	typedef struct packed {
		ray_t              ray;
		logic [MAG_W-1:0]  rem;
		logic [MAG_W-1:0]  dvd;
		logic [MAG_W-1:0]  nm;
		logic [QLOW_W-1:0] q;
		logic              sat;
		logic              sneg;
		logic              nok;
	} div_st_t;

	logic              adv;
	logic [DW:0]       dv_s;
	div_st_t           dstage_s [DW+1];
	div_st_t           dnext    [DW+1];

	logic              v_s1, v_s2, v_s3;
	logic [Q_W-1:0]    qfin;
	logic              hit_c;
	logic signed [DATA_W-1:0] st_c [3];
	logic signed [DATA_W-1:0] dr_c [3];
	logic [DATA_W-1:0] dm_c [3];

	logic              hit_s1;
	logic signed [DATA_W-1:0] st_s1 [3];
	logic              neg_s1 [3];
	logic [MAG_W-1:0]  dl_s1 [3];
	logic [MAG_W-2:0]  dh_s1 [3];

	logic              hit_s2;
	logic signed [DATA_W-1:0] st_s2 [3];
	logic              neg_s2 [3];
	logic [33:0]       m_s2 [3];
	logic [33:0]       m_c [3];
	logic [MAG_W-1:0]  tmp_c [3];

	result_t           res_s3;
	logic signed [DATA_W-1:0] pt_c [3];
	logic signed [35:0] r_c [3];

	assign adv    = !v_s3 || !res_full;
	assign mid_rd = adv && !mid_empty;

	// load the divider from the queue
	always_comb begin
		dnext[0].ray  = mid_item.ray;
		dnext[0].rem  = '0;
		dnext[0].dvd  = mid_item.zm;
		dnext[0].nm   = mid_item.nm;
		dnext[0].q    = '0;
		dnext[0].sat  = 1'b0;
		dnext[0].sneg = mid_item.sneg;
		dnext[0].nok  = mid_item.nok;
	end

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < DW; i++) begin : g_div
		localparam int WT = DW - 1 - i;
		logic [MAG_W:0] shl;
		logic [MAG_W:0] diff;
		logic           ge;
		always_comb begin
			shl  = {dstage_s[i].rem, dstage_s[i].dvd[MAG_W-1]};
			diff = shl - {1'b0, dstage_s[i].nm};
			ge   = (shl >= {1'b0, dstage_s[i].nm});
			dnext[i+1]      = dstage_s[i];
			dnext[i+1].rem  = ge ? diff[MAG_W-1:0] : shl[MAG_W-1:0];
			dnext[i+1].dvd  = dstage_s[i].dvd << 1;
			dnext[i+1].q    = {dstage_s[i].q[QLOW_W-2:0], ge};
			dnext[i+1].sat  = dstage_s[i].sat || (ge && (WT >= SAT_BIT));
		end
	end

	// advance divider valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s <= '0;
		end else if (adv) begin
			dv_s <= {dv_s[DW-1:0], mid_rd};
		end
	end

	// advance divider payload
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k <= DW; k++) begin
				dstage_s[k] <= dnext[k];
			end
		end
	end

	// saturated ray parameter and magnitude of each direction
	always_comb begin
		qfin  = dstage_s[DW].sat ? (Q_W'(1) << SAT_BIT) : {1'b0, dstage_s[DW].q};
		hit_c = dstage_s[DW].nok && (qfin > S_EPS);
		st_c[0] = dstage_s[DW].ray.start_x;
		st_c[1] = dstage_s[DW].ray.start_y;
		st_c[2] = dstage_s[DW].ray.start_z;
		dr_c[0] = dstage_s[DW].ray.dir_x;
		dr_c[1] = dstage_s[DW].ray.dir_y;
		dr_c[2] = dstage_s[DW].ray.dir_z;
		for (int k = 0; k < 3; k++) begin
			dm_c[k] = dr_c[k][DATA_W-1] ? -dr_c[k] : dr_c[k];
		end
	end

	// step products, clamp the step, add and saturate
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tmp_c[k] = (MAG_W'(dh_s1[k]) << (32 - FRAC_BITS)) + (dl_s1[k] >> FRAC_BITS);
			if ((dh_s1[k] >= (63'd1 << FRAC_BITS)) || (tmp_c[k] > MAG_W'(M_BIG))) begin
				m_c[k] = M_BIG;
			end else begin
				m_c[k] = tmp_c[k][33:0];
			end
			r_c[k] = neg_s2[k] ? (36'(st_s2[k]) - $signed({2'b00, m_s2[k]}))
			                   : (36'(st_s2[k]) + $signed({2'b00, m_s2[k]}));
			if (r_c[k] > 36'sd2147483647) begin
				pt_c[k] = 32'sh7FFF_FFFF;
			end else if (r_c[k] < -36'sd2147483648) begin
				pt_c[k] = 32'sh8000_0000;
			end else begin
				pt_c[k] = r_c[k][DATA_W-1:0];
			end
		end
	end

	// advance point-stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dv_s[DW];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// point-stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1 <= hit_c;
			hit_s2 <= hit_s1;
			for (int k = 0; k < 3; k++) begin
				st_s1[k]  <= st_c[k];
				neg_s1[k] <= dr_c[k][DATA_W-1] != dstage_s[DW].sneg;
				dl_s1[k]  <= MAG_W'(dm_c[k]) * MAG_W'(qfin[31:0]);
				dh_s1[k]  <= (MAG_W-1)'(dm_c[k]) * (MAG_W-1)'(qfin[Q_W-1:32]);
				st_s2[k]  <= st_s1[k];
				neg_s2[k] <= neg_s1[k];
				m_s2[k]   <= m_c[k];
			end
			res_s3.hit     <= hit_s2;
			res_s3.point_x <= hit_s2 ? pt_c[0] : '0;
			res_s3.point_y <= hit_s2 ? pt_c[1] : '0;
			res_s3.point_z <= hit_s2 ? pt_c[2] : '0;
		end
	end

	assign res_wr   = v_s3 && adv;
	assign res_item = res_s3;

endmodule

// File: rtl/ray_plane_intersect_core.sv
// Ray against a configured plane: one ray per cycle in, one result per ray out, in order.
// The divider resolves one bit of the ray parameter per stage (Q16.16 coordinates by default).
// A new ray is taken every cycle as long as results are drained; a two-entry queue sits between
// the dot-product front end and the divider back end, and another at the result side. The plane
// registers may be written only when no ray is in flight. A miss reports hit low and a zero point.
module ray_plane_intersect_core #(
	parameter int FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  rpi_pkg::ray_t                        ray,
	output logic                                 empty,
	input  logic                                 pop,
	output rpi_pkg::result_t                     result,
	input  logic                                 cfg_we,
	input  logic [rpi_pkg::REG_IDX_W-1:0]        cfg_idx,
	input  logic [rpi_pkg::DATA_W-1:0]           cfg_data
);
	import rpi_pkg::*;

	plane_t  cfg_q;
	logic    mid_wr, mid_rd, mid_full, mid_empty;
	mid_t    mid_in, mid_out;
	logic    res_wr, res_full;
	result_t res_in;

	// plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x     <= '0;
			cfg_q.normal_y     <= '0;
			cfg_q.normal_z     <= DATA_W'(1) << FRAC_BITS;
			cfg_q.plane_offset <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NORMAL_X:     cfg_q.normal_x     <= cfg_data;
				REG_NORMAL_Y:     cfg_q.normal_y     <= cfg_data;
				REG_NORMAL_Z:     cfg_q.normal_z     <= cfg_data;
				REG_PLANE_OFFSET: cfg_q.plane_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.ray      (ray),
		.plane    (cfg_q),
		.mid_wr   (mid_wr),
		.mid_item (mid_in),
		.mid_full (mid_full)
	);

	rpi_fifo #(.WIDTH($bits(mid_t)), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_wr),
		.wdata  (mid_in),
		.rd     (mid_rd),
		.rdata  (mid_out),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (mid_out),
		.mid_rd    (mid_rd),
		.res_wr    (res_wr),
		.res_item  (res_in),
		.res_full  (res_full)
	);

	rpi_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_in),
		.rd     (pop),
		.rdata  (result),
		.full   (res_full),
		.empty  (empty)
	);

	// a miss always carries a zero point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.hit) |->
		(result.point_x == '0 && result.point_y == '0 && result.point_z == '0))
		else $error("miss with nonzero point");

	// a normal_z write lands in the plane register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_idx == REG_NORMAL_Z) |=> (cfg_q.normal_z == $past(cfg_data)))
		else $error("normal_z write lost");

	// the queue between the parts never takes a write while full
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_full |-> !mid_wr)
		else $error("front end wrote into a full queue");

endmodule

// File: bench/ray_plane_intersect_core_tb.sv
// Self-checking testbench for the ray/plane intersection core.
`timescale 1ns / 100ps

module ray_plane_intersect_core_tb;
	import rpi_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [63:0] EPS_LSB = ((64'd1 << FRAC) + 64'd5000) / 64'd10000;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;
	localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SMIN = 32'sh8000_0000;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAYS_PER_PHASE = 205;

	typedef struct {
		bit      load;
		plane_t  plane;
		ray_t    r;
		bit      known;
		result_t want;
	} probe_t;

	logic    clk;
	logic    arst_n;
	logic    push;
	logic    full;
	ray_t    ray_word;
	logic    empty;
	logic    pop;
	result_t res_word;
	logic    cfg_we;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0]    cfg_data;

	result_t pending_points[$];
	probe_t  probes[$];
	plane_t  plane_now;
	int      errors = 0;
	int      rays_sent = 0;
	int      hits_seen = 0;
	int      results_seen = 0;
	int      send_idle = 0;
	int      recv_idle = 0;
	int      quiet_cycles = 0;

	ray_plane_intersect_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.ray      (ray_word),
		.empty    (empty),
		.pop      (pop),
		.result   (res_word),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [69:0] widen(logic signed [31:0] v);
		widen = v;
	endfunction

	// one coordinate of the hit point: start + dir*s, saturated
	function automatic logic signed [31:0] land_coord(logic signed [31:0] st,
			logic signed [31:0] d, logic [79:0] q, bit sneg);
		logic signed [63:0] d64;
		logic signed [63:0] s64;
		logic signed [63:0] r64;
		logic [63:0]  dm;
		logic [127:0] prod;
		logic [63:0]  m;
		d64 = d;
		s64 = st;
		dm = (d64 < 0) ? -d64 : d64;
		prod = dm * q;
		prod = prod >> FRAC;
		m = (prod > 128'(64'd1 << 33)) ? (64'd1 << 33) : prod[63:0];
		r64 = ((d64 < 0) != sneg) ? s64 - $signed(m) : s64 + $signed(m);
		if (r64 > 64'sh7FFF_FFFF)
			r64 = 64'sh7FFF_FFFF;
		if (r64 < -64'sh8000_0000)
			r64 = -64'sh8000_0000;
		land_coord = r64[31:0];
	endfunction

	// intersect one ray with the plane; miss gives hit low and a zero point
	function automatic result_t intersect_ray(ray_t r, plane_t p);
		logic signed [69:0] n;
		logic signed [69:0] z;
		logic [69:0] na;
		logic [69:0] za;
		logic [63:0] nm;
		logic [63:0] zm;
		logic [79:0] q;
		bit sneg;
		result_t res;
		res = '0;
		n = widen(r.dir_x) * widen(p.normal_x) + widen(r.dir_y) * widen(p.normal_y)
			+ widen(r.dir_z) * widen(p.normal_z);
		z = widen(r.start_x) * widen(p.normal_x) + widen(r.start_y) * widen(p.normal_y)
			+ widen(r.start_z) * widen(p.normal_z) + (widen(p.plane_offset) <<< FRAC);
		na = (n < 0) ? -n : n;
		za = (z < 0) ? -z : z;
		nm = na[63:0];
		zm = za[63:0];
		if (nm <= (EPS_LSB << FRAC))
			return res;
		q = (80'(zm) << FRAC) / 80'(nm);
		if (q > (80'd1 << 62))
			q = 80'd1 << 62;
		sneg = ((z < 0) == (n < 0));
		if (q <= 80'(EPS_LSB))
			return res;
		res.hit = 1'b1;
		res.point_x = land_coord(r.start_x, r.dir_x, q, sneg);
		res.point_y = land_coord(r.start_y, r.dir_y, q, sneg);
		res.point_z = land_coord(r.start_z, r.dir_z, q, sneg);
		return res;
	endfunction

	function automatic logic signed [31:0] rand_word();
		int pick;
		int k;
		logic signed [31:0] v;
		pick = $urandom_range(99);
		if (pick < 20) begin
			v = $urandom;
		end else if (pick < 80) begin
			k = $urandom_range(24, 3);
			v = $signed($urandom_range((1 << k) - 1)) - (1 << (k - 1));
		end else begin
			case ($urandom_range(8))
				0: v = 0;
				1: v = 1;
				2: v = -1;
				3: v = 7;
				4: v = 8;
				5: v = ONE;
				6: v = -ONE;
				7: v = SMAX;
				default: v = SMIN;
			endcase
		end
		return v;
	endfunction

	function automatic ray_t random_ray();
		ray_t r;
		r.start_x = rand_word();
		r.start_y = rand_word();
		r.start_z = rand_word();
		r.dir_x = rand_word();
		r.dir_y = rand_word();
		r.dir_z = rand_word();
		return r;
	endfunction

	function automatic plane_t make_plane(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d);
		plane_t p;
		p.normal_x = a;
		p.normal_y = b;
		p.normal_z = c;
		p.plane_offset = d;
		return p;
	endfunction

	// plane for each random phase: reset value, extremes, then random ones
	function automatic plane_t phase_plane(int idx);
		case (idx)
			0: return make_plane(0, 0, ONE, 0);
			1: return make_plane(SMAX, SMAX, SMAX, SMAX);
			2: return make_plane(SMIN, SMIN, SMIN, SMIN);
			3: return make_plane(SMAX, 32'sh7FF8_FFFE, SMAX, SMIN);
			4: return make_plane($urandom, $urandom, $urandom, $urandom);
			default: return make_plane(rand_word(), rand_word(), rand_word(), rand_word());
		endcase
	endfunction

	function automatic void add_ray(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] sz, logic signed [31:0] dx, logic signed [31:0] dy,
			logic signed [31:0] dz, bit known, logic h, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		probe_t pr;
		pr.load = 1'b0;
		pr.plane = '0;
		pr.r = '{sx, sy, sz, dx, dy, dz};
		pr.known = known;
		pr.want = '{h, px, py, pz};
		probes.push_back(pr);
	endfunction

	function automatic void add_load(plane_t p);
		probe_t pr;
		pr = '{1'b1, p, '0, 1'b0, '0};
		probes.push_back(pr);
	endfunction

	// present one ray, hold it until taken, log its expected result
	task automatic send_ray(ray_t r, bit known, result_t want);
		while ($urandom_range(99) < send_idle) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		ray_word = r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_points.push_back(known ? want : intersect_ray(r, plane_now));
		rays_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		push = 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = v;
	endtask

	// reprogram the plane once nothing is in flight
	task automatic load_plane(plane_t p);
		drain();
		write_reg(REG_NORMAL_X, p.normal_x);
		write_reg(REG_NORMAL_Y, p.normal_y);
		write_reg(REG_NORMAL_Z, p.normal_z);
		write_reg(REG_PLANE_OFFSET, p.plane_offset);
		@(negedge clk);
		cfg_we = 1'b0;
		plane_now = p;
	endtask

	// receiver: stall at random, set at the falling edge
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop = ($urandom_range(99) >= recv_idle);
		end
	end

	// check each result transaction against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (res_word.hit === 1'b1)
				hits_seen++;
			if (pending_points.size() == 0) begin
				$error("result with no ray pending: hit %0b point %0d %0d %0d",
					res_word.hit, res_word.point_x, res_word.point_y, res_word.point_z);
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (res_word.hit !== want.hit) begin
					$error("hit expected %0b actual %0b", want.hit, res_word.hit);
					errors++;
				end
				if (res_word.point_x !== want.point_x) begin
					$error("point_x expected %0d actual %0d", want.point_x, res_word.point_x);
					errors++;
				end
				if (res_word.point_y !== want.point_y) begin
					$error("point_y expected %0d actual %0d", want.point_y, res_word.point_y);
					errors++;
				end
				if (res_word.point_z !== want.point_z) begin
					$error("point_z expected %0d actual %0d", want.point_z, res_word.point_z);
					errors++;
				end
			end
		end
	end

	// watchdog: give up after a long stretch with no transaction at all
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		ray_word = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		plane_now = make_plane(0, 0, ONE, 0);

		// directed rows against the reset plane z = 0
		add_ray(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_ray(0, 0, ONE, 0, 0, -ONE, 1, 1, 0, 0, 0);
		add_ray(0, 0, 0, 0, 0, ONE, 1, 0, 0, 0, 0);
		add_ray(0, 0, ONE, 0, 0, 7, 1, 0, 0, 0, 0);
		add_ray(0, 0, -ONE, 0, 0, 8, 1, 1, 0, 0, 0);
		add_ray(0, 0, 1, 0, 0, -ONE, 1, 0, 0, 0, 0);
		add_ray(0, 0, 7, 0, 0, -ONE, 1, 0, 0, 0, 0);
		add_ray(0, 0, 8, 0, 0, -ONE, 1, 1, 0, 0, 0);
		add_ray(SMAX, SMIN, ONE, ONE, -ONE, -ONE, 1, 1, SMAX, SMIN, 0);
		add_ray(0, 0, SMAX, 1, -1, 8, 0, 0, 0, 0, 0);
		add_ray(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 0, 0, 0, 0, 0);
		add_ray(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 0, 0);
		add_ray(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 0, 0, 0, 0, 0);
		add_ray(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 0, 0, 0, 0, 0);
		add_ray(3 * ONE, -2 * ONE, 5 * ONE, ONE, ONE, -ONE, 0, 0, 0, 0, 0);
		// nearly cancelling normal: tiny denominator, huge parameter clamps
		add_load(phase_plane(3));
		add_ray(SMIN, SMIN, SMIN, 1, -1, 0, 0, 0, 0, 0, 0);
		add_ray(SMAX, SMAX, SMAX, 1, -1, 0, 0, 0, 0, 0, 0);
		add_ray(SMIN, SMAX, 0, -1, 1, 0, 0, 0, 0, 0, 0);
		add_ray(0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		send_idle = 17;
		recv_idle = 85;

		// walk the directed table
		foreach (probes[i]) begin
			if (probes[i].load)
				load_plane(probes[i].plane);
			else
				send_ray(probes[i].r, probes[i].known, probes[i].want);
		end

		// random rays: three idling regimes, three planes each
		for (int regime = 0; regime < 3; regime++) begin
			send_idle = (regime == 0) ? 17 : (regime == 1) ? 85 : 0;
			recv_idle = (regime == 0) ? 85 : (regime == 1) ? 17 : 0;
			for (int ph = 0; ph < 3; ph++) begin
				load_plane(phase_plane(regime * 3 + ph));
				repeat (RAYS_PER_PHASE)
					send_ray(random_ray(), 1'b0, '0);
			end
		end

		// let the pipeline empty out, then allow stray results to show up
		drain();
		repeat (120) @(posedge clk);

		$display("Sent %0d rays over %0d planes, %0d results checked, %0d hits.",
			rays_sent, 10, results_seen, hits_seen);
		$display("Covered reset, extreme and near-parallel planes under three stall mixes.");
		if (errors == 0 && pending_points.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
